[design/bertlv_pkg.sv]
// Shared types and constants for the BER tag-length header parser.
package bertlv_pkg;

  // Most long-form length octets accepted after the count octet.
  localparam logic [6:0] MAX_LENGTH_BYTES = 7'd8;
  // Most tag octets, the identifier octet included.
  localparam logic [3:0] MAX_TAG_BYTES = 4'd10;

  // Octet values that steer the decode.
  localparam logic [4:0] TAG_LOW_ESCAPE = 5'h1F;
  localparam logic [7:0] LEN_INDEFINITE = 8'h80;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_END         = 3'd1,
    STAT_BAD_SIZE    = 3'd2,
    STAT_PRIM_INDEF  = 3'd3,
    STAT_TAG_TOO_LONG = 3'd4
  } status_t;

  // Length form codes.
  typedef enum logic [1:0] {
    FORM_SHORT = 2'd0,
    FORM_LONG  = 2'd1,
    FORM_INDEF = 2'd2
  } form_t;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_TAG_MORE  = 4'b0010,
    PH_LEN_FIRST = 4'b0100,
    PH_LEN_MORE  = 4'b1000
  } phase_t;

  // Parser state carried from one word to the next.
  typedef struct packed {
    phase_t      phase;
    logic [31:0] byte_index;
    logic [63:0] tag_accum;
    logic [1:0]  class_reg;
    logic        constructed_reg;
    logic [3:0]  tag_count;
    logic [63:0] length_accum;
    logic [3:0]  length_to_read;
    form_t       form_reg;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:           PH_IDLE,
    byte_index:      32'd0,
    tag_accum:       64'd0,
    class_reg:       2'd0,
    constructed_reg: 1'b0,
    tag_count:       4'd0,
    length_accum:    64'd0,
    length_to_read:  4'd0,
    form_reg:        FORM_SHORT
  };

  // One decoded header result.
  typedef struct packed {
    status_t     status;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [63:0] tag_number;
    form_t       length_form;
    logic [63:0] length_value;
    logic [3:0]  tag_octets;
    logic [3:0]  length_octets;
    logic [31:0] error_offset;
  } result_t;

endpackage

[design/bertlv_byte_if.sv]
// Valid/ready channel that carries one buffer byte per word.
interface bertlv_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [31:0] bytes_left;

  modport source (output valid, output data_byte, output first_byte, output bytes_left,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input bytes_left,
                output ready);
endinterface

[design/bertlv_hdr_if.sv]
// Valid/ready channel that carries one decoded header result per word.
interface bertlv_hdr_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  tag_class;
  logic        constructed;
  logic [63:0] tag_number;
  logic [1:0]  length_form;
  logic [63:0] length_value;
  logic [3:0]  tag_octets;
  logic [3:0]  length_octets;
  logic [31:0] error_offset;

  modport source (output valid, output status, output tag_class, output constructed,
                  output tag_number, output length_form, output length_value,
                  output tag_octets, output length_octets, output error_offset,
                  input ready);
  modport sink (input valid, input status, input tag_class, input constructed,
                input tag_number, input length_form, input length_value,
                input tag_octets, input length_octets, input error_offset,
                output ready);
endinterface

[design/bertlv_step.sv]
// Next-state and result logic for one accepted header byte.
module bertlv_step (
  input  bertlv_pkg::state_t  st,
  input  logic [7:0]          data_byte,
  input  logic                first_byte,
  input  logic [31:0]         bytes_left,
  output bertlv_pkg::state_t  st_next,
  output logic                emit,
  output bertlv_pkg::result_t res
);
  import bertlv_pkg::*;

  always_comb begin
    logic [31:0] idx;
    logic [3:0]  tag_count_inc;
    logic [63:0] accum_inc;
    logic [3:0]  to_read_dec;
    logic [6:0]  count;
    logic        err;
    logic        ok;
    status_t     err_code;
    logic [31:0] err_where;
    form_t       ok_form;
    logic [63:0] ok_len;
    logic [3:0]  ok_lsize;

    st_next       = st;
    idx           = st.byte_index;
    tag_count_inc = st.tag_count + 4'd1;
    accum_inc     = {st.length_accum[55:0], data_byte};
    to_read_dec   = st.length_to_read - 4'd1;
    count         = data_byte[6:0];
    err           = 1'b0;
    ok            = 1'b0;
    err_code      = STAT_OK;
    err_where     = 32'd0;
    ok_form       = FORM_SHORT;
    ok_len        = 64'd0;
    ok_lsize      = 4'd1;

    if (first_byte) begin
      // Identifier octet: restart the header.
      st_next.byte_index      = 32'd1;
      st_next.class_reg       = data_byte[7:6];
      st_next.constructed_reg = data_byte[5];
      st_next.tag_count       = 4'd1;
      st_next.length_accum    = 64'd0;
      st_next.length_to_read  = 4'd0;
      st_next.form_reg        = FORM_SHORT;
      if (bytes_left == 32'd0) begin
        err      = 1'b1;
        err_code = STAT_END;
      end else if (data_byte[4:0] == TAG_LOW_ESCAPE) begin
        st_next.tag_accum = 64'd0;
        st_next.phase     = PH_TAG_MORE;
      end else begin
        st_next.tag_accum = {59'd0, data_byte[4:0]};
        st_next.phase     = PH_LEN_FIRST;
      end
    end else begin
      unique case (st.phase)
        PH_IDLE: begin
          // Stray bytes between headers are dropped.
        end
        PH_TAG_MORE: begin
          // Further 7-bit groups of the tag number.
          st_next.byte_index = idx + 32'd1;
          if (bytes_left == 32'd0) begin
            err       = 1'b1;
            err_code  = STAT_END;
            err_where = idx;
          end else begin
            st_next.tag_accum = {st.tag_accum[56:0], data_byte[6:0]};
            st_next.tag_count = tag_count_inc;
            if (data_byte[7]) begin
              if (tag_count_inc >= MAX_TAG_BYTES) begin
                err       = 1'b1;
                err_code  = STAT_TAG_TOO_LONG;
                err_where = idx;
              end
            end else begin
              st_next.phase = PH_LEN_FIRST;
            end
          end
        end
        PH_LEN_FIRST: begin
          // First length octet picks the form.
          st_next.byte_index = idx + 32'd1;
          if (data_byte == LEN_INDEFINITE) begin
            if (!st.constructed_reg) begin
              err       = 1'b1;
              err_code  = STAT_PRIM_INDEF;
              err_where = idx;
            end else begin
              st_next.form_reg = FORM_INDEF;
              ok      = 1'b1;
              ok_form = FORM_INDEF;
              ok_len  = '1;
            end
          end else if (!data_byte[7]) begin
            if (bytes_left < {24'd0, data_byte}) begin
              err       = 1'b1;
              err_code  = STAT_END;
              err_where = idx;
            end else begin
              st_next.form_reg = FORM_SHORT;
              ok      = 1'b1;
              ok_form = FORM_SHORT;
              ok_len  = {56'd0, data_byte};
            end
          end else if (count > MAX_LENGTH_BYTES) begin
            err       = 1'b1;
            err_code  = STAT_BAD_SIZE;
            err_where = idx;
          end else if (bytes_left < {25'd0, count}) begin
            err       = 1'b1;
            err_code  = STAT_END;
            err_where = idx + bytes_left;
          end else begin
            st_next.length_accum   = 64'd0;
            st_next.length_to_read = count[3:0];
            st_next.form_reg       = FORM_LONG;
            st_next.phase          = PH_LEN_MORE;
          end
        end
        PH_LEN_MORE: begin
          // Long-form length octets, big-endian.
          st_next.byte_index     = idx + 32'd1;
          st_next.length_accum   = accum_inc;
          st_next.length_to_read = to_read_dec;
          if (to_read_dec == 4'd0) begin
            if (accum_inc > {32'd0, bytes_left}) begin
              err       = 1'b1;
              err_code  = STAT_BAD_SIZE;
              err_where = {28'd0, st.tag_count};
            end else begin
              ok       = 1'b1;
              ok_form  = FORM_LONG;
              ok_len   = accum_inc;
              ok_lsize = idx[3:0] - st.tag_count + 4'd1;
            end
          end
        end
        default: begin
          st_next.phase = PH_IDLE;
        end
      endcase
    end

    // Any result closes the header.
    if (err || ok) begin
      st_next.phase = PH_IDLE;
    end

    emit = err || ok;
    res  = '0;
    if (err) begin
      res.status       = err_code;
      res.error_offset = err_where;
    end else begin
      res.status        = STAT_OK;
      res.tag_class     = st_next.class_reg;
      res.constructed   = st_next.constructed_reg;
      res.tag_number    = st_next.tag_accum;
      res.length_form   = ok_form;
      res.length_value  = ok_len;
      res.tag_octets    = st_next.tag_count;
      res.length_octets = ok_lsize;
    end
  end

endmodule

[design/ber_tlv_header_parser.sv]
// Top level of the BER tag-length header parser.
//
// Usage: buffer bytes arrive on byte_ch, one word per byte, with first_byte
// set on the identifier octet of each header and bytes_left giving how many
// buffer bytes follow that byte. Decoded headers leave on hdr_ch, one word
// per header: tag class, constructed bit, tag number, length form and value,
// the sizes of both fields, or an error status with its offset.
// Throughput is one byte per cycle while byte_ch is ready: each byte
// updates the small parser state in combinational logic ahead of the result
// register. A result is visible on hdr_ch in the cycle after the byte that
// completes the header or finds the error. Bytes that follow a finished
// header are dropped until the next first byte.
// Reset clears the parser to idle and empties the result register.
// The result register holds a waiting word while hdr_ch is stalled; byte_ch
// keeps taking bytes as long as the result register is empty or is being
// emptied in the same cycle, so a stall blocks input only while a finished
// result still waits.
module ber_tlv_header_parser (
  input logic         clk,
  input logic         rst,
  bertlv_byte_if.sink byte_ch,
  bertlv_hdr_if.source hdr_ch
);
  import bertlv_pkg::*;

  state_t  st;
  state_t  st_next;
  logic    emit;
  result_t res;
  result_t hdr;
  logic    hdr_valid;
  logic    accept;

  assign byte_ch.ready = !hdr_valid || hdr_ch.ready;
  assign accept        = byte_ch.valid && byte_ch.ready;

  bertlv_step u_step (
    .st         (st),
    .data_byte  (byte_ch.data_byte),
    .first_byte (byte_ch.first_byte),
    .bytes_left (byte_ch.bytes_left),
    .st_next    (st_next),
    .emit       (emit),
    .res        (res)
  );

  // Parser state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (accept && emit) begin
      hdr_valid <= 1'b1;
    end else if (hdr_ch.ready) begin
      hdr_valid <= 1'b0;
    end
  end

  // Result payload is loaded only when a header completes or ends in an error.
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      hdr <= res;
    end
  end

  assign hdr_ch.valid         = hdr_valid;
  assign hdr_ch.status        = hdr.status;
  assign hdr_ch.tag_class     = hdr.tag_class;
  assign hdr_ch.constructed   = hdr.constructed;
  assign hdr_ch.tag_number    = hdr.tag_number;
  assign hdr_ch.length_form   = hdr.length_form;
  assign hdr_ch.length_value  = hdr.length_value;
  assign hdr_ch.tag_octets    = hdr.tag_octets;
  assign hdr_ch.length_octets = hdr.length_octets;
  assign hdr_ch.error_offset  = hdr.error_offset;

endmodule

[design/bertlv_checker.sv]
// Port-level checks for the BER tag-length header parser, bound to the top level.
module bertlv_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_ready,
  input logic        hdr_valid,
  input logic        hdr_ready,
  input logic [2:0]  status,
  input logic [63:0] tag_number,
  input logic [63:0] length_value,
  input logic [3:0]  tag_octets,
  input logic [3:0]  length_octets,
  input logic [31:0] error_offset
);
  import bertlv_pkg::*;

  // A stalled result word holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && !hdr_ready |=> hdr_valid && $stable(status) && $stable(tag_number)
      && $stable(length_value) && $stable(error_offset))
    else $error("stalled header result changed");

  // With no result waiting, input is never held off.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !hdr_valid |-> byte_ready)
    else $error("input stalled while result register empty");

  // A new result only follows an accepted byte.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(hdr_valid) |-> $past(byte_valid && byte_ready))
    else $error("result appeared without an accepted byte");

  // Error results carry only status and offset.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && status != STAT_OK |->
      tag_number == 64'd0 && length_value == 64'd0 && tag_octets == 4'd0
      && length_octets == 4'd0)
    else $error("error result carries header fields");

  // Good results have no offset and non-empty fields.
  a_ok_sizes: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && status == STAT_OK |->
      error_offset == 32'd0 && tag_octets != 4'd0 && length_octets != 4'd0)
    else $error("good result with bad sizes or offset");

endmodule

bind ber_tlv_header_parser bertlv_checker u_bertlv_checker (
  .clk           (clk),
  .rst           (rst),
  .byte_valid    (byte_ch.valid),
  .byte_ready    (byte_ch.ready),
  .hdr_valid     (hdr_ch.valid),
  .hdr_ready     (hdr_ch.ready),
  .status        (hdr_ch.status),
  .tag_number    (hdr_ch.tag_number),
  .length_value  (hdr_ch.length_value),
  .tag_octets    (hdr_ch.tag_octets),
  .length_octets (hdr_ch.length_octets),
  .error_offset  (hdr_ch.error_offset)
);

[tb/sv/testbench.sv]
// Testbench for the BER tag-length header parser: byte driver, result monitor and header decoder.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bertlv_pkg::*;

  // Watchdog limit, well above what a slow correct run needs.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Cycles allowed after the last header before the verdict.
  localparam int unsigned TAIL_CYCLES = 8;
  // Least number of header and noise bytes queued in each idling phase.
  localparam int unsigned PHASE_BYTES = 460;

  // One buffer byte waiting to be driven.
  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic [31:0] left;
    bit          drain;
  } byte_item_t;

  logic clk = 1'b0;
  logic rst;

  bertlv_byte_if byte_ch ();
  bertlv_hdr_if  hdr_ch ();

  ber_tlv_header_parser dut (
    .clk    (clk),
    .rst    (rst),
    .byte_ch(byte_ch),
    .hdr_ch (hdr_ch)
  );

  byte_item_t  byte_queue[$];
  result_t     hdr_expected[$];
  state_t      parse_state;
  byte_item_t  next_item;
  logic        byte_taken;
  int unsigned sender_idle;
  int unsigned receiver_stall;
  int unsigned fail_count;
  int unsigned headers_checked;
  int unsigned bytes_queued;
  int unsigned bytes_accepted;
  int unsigned gen_count;
  int unsigned cycle_count;

  int unsigned idle_pct[4]  = '{0, 83, 0, 21};
  int unsigned stall_pct[4] = '{0, 0, 83, 21};

  always #5 clk = ~clk;

  // Print one line per mismatch and count it.
  task automatic report_fault(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      report_fault($sformatf("header %0d: %s is %0h, expected %0h",
                             headers_checked, name, got, want));
    end
  endtask

  // An error result carries only its status and offset.
  task automatic emit_fault(input status_t code, input logic [31:0] where);
    result_t r;
    r = '0;
    r.status = code;
    r.error_offset = where;
    hdr_expected.push_back(r);
    parse_state.phase = PH_IDLE;
  endtask

  task automatic emit_header(input form_t form, input logic [63:0] len, input logic [3:0] lsize);
    result_t r;
    r = '0;
    r.status = STAT_OK;
    r.tag_class = parse_state.class_reg;
    r.constructed = parse_state.constructed_reg;
    r.tag_number = parse_state.tag_accum;
    r.length_form = form;
    r.length_value = len;
    r.tag_octets = parse_state.tag_count;
    r.length_octets = lsize;
    hdr_expected.push_back(r);
    parse_state.phase = PH_IDLE;
  endtask

  // Advance the decoder by one accepted byte; a finished header queues its result.
  task automatic parse_byte(input logic [7:0] b, input logic first, input logic [31:0] left);
    logic [31:0] idx;
    logic [6:0]  n;
    logic [31:0] lsize;
    if (first) begin
      parse_state.byte_index = 32'd1;
      parse_state.class_reg = b[7:6];
      parse_state.constructed_reg = b[5];
      parse_state.tag_count = 4'd1;
      parse_state.length_accum = 64'd0;
      parse_state.length_to_read = 4'd0;
      parse_state.form_reg = FORM_SHORT;
      if (left == 32'd0) begin
        emit_fault(STAT_END, 32'd0);
      end else if (b[4:0] == TAG_LOW_ESCAPE) begin
        parse_state.tag_accum = 64'd0;
        parse_state.phase = PH_TAG_MORE;
      end else begin
        parse_state.tag_accum = {59'd0, b[4:0]};
        parse_state.phase = PH_LEN_FIRST;
      end
    end else if (parse_state.phase != PH_IDLE) begin
      idx = parse_state.byte_index;
      parse_state.byte_index = idx + 32'd1;
      case (parse_state.phase)
        PH_TAG_MORE: begin
          if (left == 32'd0) begin
            emit_fault(STAT_END, idx);
          end else begin
            parse_state.tag_accum = {parse_state.tag_accum[56:0], b[6:0]};
            parse_state.tag_count = parse_state.tag_count + 4'd1;
            if (b[7]) begin
              if (parse_state.tag_count >= MAX_TAG_BYTES) emit_fault(STAT_TAG_TOO_LONG, idx);
            end else begin
              parse_state.phase = PH_LEN_FIRST;
            end
          end
        end
        PH_LEN_FIRST: begin
          if (b == LEN_INDEFINITE) begin
            if (!parse_state.constructed_reg) begin
              emit_fault(STAT_PRIM_INDEF, idx);
            end else begin
              parse_state.form_reg = FORM_INDEF;
              emit_header(FORM_INDEF, '1, 4'd1);
            end
          end else if (!b[7]) begin
            if (left < {24'd0, b}) begin
              emit_fault(STAT_END, idx);
            end else begin
              parse_state.form_reg = FORM_SHORT;
              emit_header(FORM_SHORT, {56'd0, b}, 4'd1);
            end
          end else begin
            n = b[6:0];
            if (n > MAX_LENGTH_BYTES) begin
              emit_fault(STAT_BAD_SIZE, idx);
            end else if (left < {25'd0, n}) begin
              // The offset points at the last byte of the buffer.
              emit_fault(STAT_END, idx + left);
            end else begin
              parse_state.length_accum = 64'd0;
              parse_state.length_to_read = n[3:0];
              parse_state.form_reg = FORM_LONG;
              parse_state.phase = PH_LEN_MORE;
            end
          end
        end
        default: begin
          parse_state.length_accum = {parse_state.length_accum[55:0], b};
          parse_state.length_to_read = parse_state.length_to_read - 4'd1;
          if (parse_state.length_to_read == 4'd0) begin
            lsize = idx - {28'd0, parse_state.tag_count} + 32'd1;
            if (parse_state.length_accum > {32'd0, left}) begin
              emit_fault(STAT_BAD_SIZE, {28'd0, parse_state.tag_count});
            end else begin
              emit_header(FORM_LONG, parse_state.length_accum, lsize[3:0]);
            end
          end
        end
      endcase
    end
  endtask

  task automatic push_byte(input logic [7:0] data, input logic first, input logic [31:0] left,
                           input bit drain, input bit counts);
    byte_item_t it;
    it.data = data;
    it.first = first;
    it.left = left;
    it.drain = drain;
    byte_queue.push_back(it);
    bytes_queued++;
    if (counts) gen_count++;
  endtask

  // Queue one header, mostly well formed, sometimes cut short or sized wrong.
  task automatic queue_header(input bit drain);
    logic [7:0]  hdr[$];
    logic [7:0]  id;
    logic [7:0]  vb;
    logic [63:0] content;
    logic [63:0] buffer_len;
    logic [63:0] left64;
    int unsigned lkind, cont, n, k, i, cut, r;
    lkind = $urandom_range(99);
    id = 8'($urandom_range(255));
    if ($urandom_range(99) < 55) id[4:0] = 5'($urandom_range(30));
    else id[4:0] = TAG_LOW_ESCAPE;
    // Indefinite length mostly goes with a constructed tag.
    if (lkind >= 70 && lkind < 85 && $urandom_range(99) < 80) id[5] = 1'b1;
    hdr.push_back(id);
    if (id[4:0] == TAG_LOW_ESCAPE) begin
      r = $urandom_range(99);
      if (r < 70) cont = $urandom_range(1, 3);
      else if (r < 92) cont = $urandom_range(4, 9);
      else cont = $urandom_range(10, 12);
      for (i = 0; i < cont; i++) begin
        vb = 8'($urandom_range(255));
        vb[7] = (i != cont - 1);
        hdr.push_back(vb);
      end
    end
    content = 64'd0;
    if (lkind < 35) begin
      vb = 8'($urandom_range(127));
      hdr.push_back(vb);
      content = {56'd0, vb};
    end else if (lkind < 70) begin
      n = $urandom_range(1, 8);
      hdr.push_back(8'h80 | n[7:0]);
      if ($urandom_range(99) < 85) k = $urandom_range(0, (n < 3) ? n : 3);
      else k = $urandom_range(0, n);
      for (i = 0; i < n; i++) begin
        vb = (i >= n - k) ? 8'($urandom) : 8'h00;
        hdr.push_back(vb);
        content = {content[55:0], vb};
      end
    end else if (lkind < 85) begin
      hdr.push_back(LEN_INDEFINITE);
    end else begin
      hdr.push_back(8'($urandom_range(8'h89, 8'hFF)));
    end
    r = $urandom_range(99);
    if (r < 75) buffer_len = 64'(hdr.size()) + content + 64'($urandom_range(0, 3));
    else if (r < 85) buffer_len = 64'($urandom_range(1, hdr.size()));
    else if (r < 92) buffer_len = 64'(hdr.size()) + content - 64'((content != 0) ? 1 : 0);
    else buffer_len = {32'd0, $urandom};
    // Now and then the header is abandoned and the next first byte restarts parsing.
    cut = hdr.size();
    if ($urandom_range(99) < 6) cut = $urandom_range(1, hdr.size());
    for (i = 0; i < cut && 64'(i) < buffer_len; i++) begin
      left64 = buffer_len - 64'd1 - 64'(i);
      push_byte(hdr[i], i == 0, (left64 > 64'hFFFF_FFFF) ? '1 : left64[31:0],
                drain && i == 0, 1'b1);
    end
    // Stray bytes after a header are dropped by the block.
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) push_byte(8'($urandom), 1'b0, $urandom, 1'b0, 1'b0);
    end
  endtask

  // Random bytes with random first flags and sizes.
  task automatic queue_noise();
    logic [31:0] left;
    int unsigned i, count;
    count = $urandom_range(1, 4);
    for (i = 0; i < count; i++) begin
      left = $urandom_range(1) ? $urandom_range(5) : $urandom;
      push_byte(8'($urandom), $urandom_range(99) < 35, left, 1'b0, 1'b1);
    end
  endtask

  // Byte driver: presents the next word at the falling edge.
  always @(negedge clk) begin : drive_bytes
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else if (!byte_ch.valid || byte_taken) begin
      if (byte_queue.size() != 0 && !(byte_queue[0].drain && hdr_expected.size() != 0) &&
          $urandom_range(99) >= sender_idle) begin
        next_item = byte_queue.pop_front();
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= next_item.data;
        byte_ch.first_byte <= next_item.first;
        byte_ch.bytes_left <= next_item.left;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls at random.
  always @(negedge clk) begin : drive_ready
    hdr_ch.ready <= ($urandom_range(99) >= receiver_stall);
  end

  // Monitor: checks results, then predicts from the byte taken at this edge.
  always @(posedge clk) begin : watch_ports
    result_t want;
    if (rst) begin
      byte_taken <= 1'b0;
      parse_state = STATE_RESET;
    end else begin
      if (hdr_ch.valid && hdr_ch.ready) begin
        if (hdr_expected.size() == 0) begin
          report_fault($sformatf("result with status %0d and no header pending",
                                 hdr_ch.status));
        end else begin
          want = hdr_expected.pop_front();
          check_field("status", 64'(hdr_ch.status), 64'(want.status));
          check_field("tag_class", 64'(hdr_ch.tag_class), 64'(want.tag_class));
          check_field("constructed", 64'(hdr_ch.constructed), 64'(want.constructed));
          check_field("tag_number", hdr_ch.tag_number, want.tag_number);
          check_field("length_form", 64'(hdr_ch.length_form), 64'(want.length_form));
          check_field("length_value", hdr_ch.length_value, want.length_value);
          check_field("tag_octets", 64'(hdr_ch.tag_octets), 64'(want.tag_octets));
          check_field("length_octets", 64'(hdr_ch.length_octets), 64'(want.length_octets));
          check_field("error_offset", 64'(hdr_ch.error_offset), 64'(want.error_offset));
          headers_checked++;
        end
      end
      byte_taken <= byte_ch.valid && byte_ch.ready;
      if (byte_ch.valid && byte_ch.ready) begin
        parse_byte(byte_ch.data_byte, byte_ch.first_byte, byte_ch.bytes_left);
        bytes_accepted++;
      end
    end
  end

  // Cycle limit for a hung run.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned ph, i;
    bit first_unit;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.first_byte = 1'b0;
    byte_ch.bytes_left = 32'd0;
    hdr_ch.ready = 1'b0;
    sender_idle = 0;
    receiver_stall = 0;
    fail_count = 0;
    headers_checked = 0;
    bytes_queued = 0;
    bytes_accepted = 0;
    gen_count = 0;
    cycle_count = 0;
    parse_state = STATE_RESET;

    // Identifier octet that is also the last byte of the buffer.
    push_byte(8'h1F, 1'b1, 32'd0, 1'b0, 1'b1);
    // Constructed tag with indefinite length.
    push_byte(8'h30, 1'b1, 32'd1, 1'b0, 1'b1);
    push_byte(LEN_INDEFINITE, 1'b0, 32'd0, 1'b0, 1'b1);
    // Primitive tag with indefinite length.
    push_byte(8'h04, 1'b1, 32'd1, 1'b0, 1'b1);
    push_byte(LEN_INDEFINITE, 1'b0, 32'd0, 1'b0, 1'b1);
    // Short length that overruns the buffer.
    push_byte(8'h02, 1'b1, 32'd5, 1'b0, 1'b1);
    push_byte(8'h7F, 1'b0, 32'd4, 1'b0, 1'b1);
    // Long form announcing far too many length octets.
    push_byte(8'h02, 1'b1, 32'd200, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b0, 32'd199, 1'b0, 1'b1);
    // Four length octets announced with only two bytes left.
    push_byte(8'h02, 1'b1, 32'd3, 1'b0, 1'b1);
    push_byte(8'h84, 1'b0, 32'd2, 1'b0, 1'b1);
    // Buffer ends inside a multi-byte tag.
    push_byte(8'h5F, 1'b1, 32'd5, 1'b0, 1'b1);
    push_byte(8'h81, 1'b0, 32'd0, 1'b0, 1'b1);
    // Long length one octet long that exceeds what is left.
    push_byte(8'h02, 1'b1, 32'd3, 1'b0, 1'b1);
    push_byte(8'h81, 1'b0, 32'd2, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b0, 32'd1, 1'b0, 1'b1);
    // Tag whose tenth octet still has its continuation bit set.
    push_byte(8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1);
    for (i = 0; i < 9; i++) push_byte(8'hFF, 1'b0, 32'hFFFF_FFFE - i, 1'b0, 1'b1);
    // Stray byte while idle.
    push_byte(8'h00, 1'b0, 32'd0, 1'b0, 1'b1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Random headers under each idling pattern.
    for (ph = 0; ph < 4; ph++) begin
      while (byte_queue.size() != 0) @(posedge clk);
      sender_idle = idle_pct[ph];
      receiver_stall = stall_pct[ph];
      gen_count = 0;
      first_unit = 1'b1;
      while (gen_count < PHASE_BYTES) begin
        if (first_unit || $urandom_range(99) < 88) begin
          queue_header(first_unit || $urandom_range(59) == 0);
        end else begin
          queue_noise();
        end
        first_unit = 1'b0;
      end
    end

    while (bytes_accepted != bytes_queued) @(negedge clk);
    receiver_stall = 0;
    while (hdr_expected.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
design/bertlv_pkg.sv
design/bertlv_byte_if.sv
design/bertlv_hdr_if.sv
design/bertlv_step.sv
design/ber_tlv_header_parser.sv
design/bertlv_checker.sv
tb/sv/testbench.sv
